@@ design/darf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package darf_pkg;

    localparam int MAX_RULES_DEF = 16;
    localparam int BUILTIN_COUNT = 12;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;
    localparam int NUM_W     = 32;
    localparam int FLAGS_W   = 6;
    localparam int ENTRY_W   = FLAGS_W + 2 * NUM_W;

    localparam logic       CMD_ADD    = 1'b0;
    localparam logic       CMD_CHECK  = 1'b1;
    localparam logic [1:0] TYPE_BLOCK = 2'd1;
    localparam logic [1:0] TYPE_CHAR  = 2'd2;
    localparam logic [2:0] ACC_NONE   = 3'd0;
    localparam logic [2:0] ACC_MKNOD  = 3'd1;
    localparam logic [2:0] ACC_ALL    = 3'd7;
    localparam logic [NUM_W-1:0] ANY_NUM   = {NUM_W{1'b1}};
    localparam logic [NUM_W-1:0] MAJ_MEM   = 32'd1;
    localparam logic [NUM_W-1:0] MAJ_TTY   = 32'd5;
    localparam logic [NUM_W-1:0] MAJ_MISC  = 32'd10;
    localparam logic [NUM_W-1:0] MAJ_PTS   = 32'd136;
    localparam logic [NUM_W-1:0] MIN_PTMX  = 32'd200;

    typedef struct packed {
        logic [1:0]       dtype;
        logic [2:0]       acc;
        logic [NUM_W-1:0] major;
        logic [NUM_W-1:0] minor;
    } rule_t;

    localparam rule_t BUILTINS [BUILTIN_COUNT] = '{
        '{TYPE_CHAR,  ACC_MKNOD, ANY_NUM,  ANY_NUM},
        '{TYPE_BLOCK, ACC_MKNOD, ANY_NUM,  ANY_NUM},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_MEM,  32'd3},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_MEM,  32'd8},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_MEM,  32'd7},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_TTY,  32'd0},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_MEM,  32'd5},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_MEM,  32'd9},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_TTY,  32'd1},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_PTS,  ANY_NUM},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_TTY,  32'd2},
        '{TYPE_CHAR,  ACC_ALL,   MAJ_MISC, MIN_PTMX}
    };

    typedef enum logic [1:0] {
        RES_BUILTIN,
        RES_DEFAULT,
        RES_RULE
    } res_src_t;

    typedef struct packed {
        logic     capture;
        logic     do_add;
        logic     start_scan;
        logic     step_scan;
        logic     set_res;
        res_src_t res_src;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic is_add;
        logic builtin_hit;
        logic count_zero;
        logic rule_hit;
        logic ptr_zero;
    } sts_t;

    function automatic logic rule_match(
        input rule_t            r,
        input logic [1:0]       qtype,
        input logic [2:0]       qacc,
        input logic [NUM_W-1:0] qmaj,
        input logic [NUM_W-1:0] qmin
    );
        logic hit;
        begin
            hit = (r.dtype == qtype)
                && ((qacc & r.acc) == qacc)
                && ((r.major == ANY_NUM) || (r.major == qmaj))
                && ((r.minor == ANY_NUM) || (r.minor == qmin));
            return hit;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/device_access_rule_filter_core.sv @@
// Add, or check decided by a built-in rule or an empty table: accept and capture in ST_IDLE,
// decide in ST_START, load the output register in ST_DONE. Check scanning stored rules: ST_SCAN
// compares up to MAX_RULES stored rules, one rule RAM read per cycle, newest first.
// One request in flight: the next is accepted the cycle after the result is registered, later
// while an older result still waits.
// Reset: rule count 0, default verdict allow; table contents undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module device_access_rule_filter_core #(
    parameter int MAX_RULES = darf_pkg::MAX_RULES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // rule_allow, dev_type[1:0], access_mask[2:0], dev_major[31:0], dev_minor[31:0], zero pad
    input  wire logic [darf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // allowed, status, zero pad
    output logic      [darf_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    darf_pkg::cmd_t cmd;
    darf_pkg::sts_t sts;

    darf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .sts    (sts),
        .cmd    (cmd)
    );

    darf_datapath #(
        .MAX_RULES(MAX_RULES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_tdata(s_axis_tdata),
        .s_tuser(s_axis_tuser),
        .m_tdata(m_axis_tdata),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

`default_nettype wire

@@ design/darf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module darf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/darf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module darf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire darf_pkg::sts_t sts,
    output darf_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_src  = darf_pkg::RES_DEFAULT;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.is_add)
                begin
                    cmd.do_add = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.builtin_hit)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_src = darf_pkg::RES_BUILTIN;
                    state_next  = ST_DONE;
                end
                else if (sts.count_zero)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_src = darf_pkg::RES_DEFAULT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.rule_hit)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_src = darf_pkg::RES_RULE;
                    state_next  = ST_DONE;
                end
                else if (sts.ptr_zero)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_src = darf_pkg::RES_DEFAULT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.step_scan = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ design/darf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module darf_datapath #(
    parameter int MAX_RULES = darf_pkg::MAX_RULES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [darf_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    output logic      [darf_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire darf_pkg::cmd_t                 cmd,
    output darf_pkg::sts_t                      sts
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int NW    = darf_pkg::NUM_W;

    logic             q_cmd_reg;
    logic             q_allow_reg;
    logic [1:0]       q_type_reg;
    logic [2:0]       q_acc_reg;
    logic [NW-1:0]    q_maj_reg;
    logic [NW-1:0]    q_min_reg;
    logic [CNT_W-1:0] count_reg;
    logic             default_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic             res_allowed_reg;
    logic             res_status_reg;
    logic [darf_pkg::M_TDATA_W-1:0] out_tdata_reg;

    logic             is_typed;
    logic             full;
    logic [2:0]       store_acc;
    logic [CNT_W-1:0] cnt_m1;
    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [darf_pkg::ENTRY_W-1:0] ram_wdata;
    logic [darf_pkg::ENTRY_W-1:0] ram_rdata;
    darf_pkg::rule_t  stored_rule;
    logic             stored_allow;
    logic             builtin_hit;

    assign is_typed  = (q_type_reg == darf_pkg::TYPE_BLOCK) || (q_type_reg == darf_pkg::TYPE_CHAR);
    assign full      = count_reg >= CNT_W'(MAX_RULES);
    assign store_acc = (q_acc_reg == darf_pkg::ACC_NONE) ? darf_pkg::ACC_ALL : q_acc_reg;
    assign cnt_m1    = count_reg - CNT_W'(1);

    // entry: {acc, type, allow, major, minor}
    assign ram_we    = cmd.do_add && is_typed && !full;
    assign ram_wdata = {store_acc, q_type_reg, q_allow_reg, q_maj_reg, q_min_reg};
    assign ram_re    = cmd.start_scan || cmd.step_scan;
    assign ram_raddr = cmd.start_scan ? cnt_m1[IDX_W-1:0] : (ptr_reg - IDX_W'(1));

    darf_ram #(
        .WIDTH(darf_pkg::ENTRY_W),
        .DEPTH(MAX_RULES)
    ) u_rule_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[IDX_W-1:0]),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign stored_rule.acc   = ram_rdata[2*NW+5:2*NW+3];
    assign stored_rule.dtype = ram_rdata[2*NW+2:2*NW+1];
    assign stored_allow      = ram_rdata[2*NW];
    assign stored_rule.major = ram_rdata[2*NW-1:NW];
    assign stored_rule.minor = ram_rdata[NW-1:0];

    always_comb
    begin
        builtin_hit = 1'b0;
        for (int i = 0; i < darf_pkg::BUILTIN_COUNT; i++)
        begin
            if (darf_pkg::rule_match(darf_pkg::BUILTINS[i], q_type_reg, q_acc_reg,
                                     q_maj_reg, q_min_reg))
            begin
                builtin_hit = 1'b1;
            end
        end
    end

    assign sts.is_add      = (q_cmd_reg == darf_pkg::CMD_ADD);
    assign sts.builtin_hit = builtin_hit;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.rule_hit    = darf_pkg::rule_match(stored_rule, q_type_reg, q_acc_reg,
                                                  q_maj_reg, q_min_reg);
    assign sts.ptr_zero    = (ptr_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            default_reg <= 1'b1;
        end
        else if (cmd.do_add)
        begin
            if (!is_typed)
            begin
                count_reg   <= '0;
                default_reg <= q_allow_reg;
            end
            else if (!full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_cmd_reg   <= s_tuser;
            q_allow_reg <= s_tdata[0];
            q_type_reg  <= s_tdata[2:1];
            q_acc_reg   <= s_tdata[5:3];
            q_maj_reg   <= s_tdata[NW+5:6];
            q_min_reg   <= s_tdata[2*NW+5:NW+6];
        end
        if (cmd.start_scan)
        begin
            ptr_reg <= cnt_m1[IDX_W-1:0];
        end
        else if (cmd.step_scan)
        begin
            ptr_reg <= ptr_reg - IDX_W'(1);
        end
        if (cmd.do_add)
        begin
            res_allowed_reg <= 1'b0;
            res_status_reg  <= is_typed && full;
        end
        else if (cmd.set_res)
        begin
            res_status_reg <= 1'b0;
            case (cmd.res_src)
                darf_pkg::RES_BUILTIN: res_allowed_reg <= 1'b1;
                darf_pkg::RES_RULE:    res_allowed_reg <= stored_allow;
                default:               res_allowed_reg <= default_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            out_tdata_reg <= {{(darf_pkg::M_TDATA_W-2){1'b0}}, res_status_reg, res_allowed_reg};
        end
    end

    assign m_tdata = out_tdata_reg;

endmodule

`default_nettype wire
